// File: rtl/core/balloc_pkg.sv
// Shared types and constants for the bitmap allocator.
// Holds field widths, operation and status codes, the sequencer states and the result record.
// No dependencies.
package balloc_pkg;

   // Default geometry; all three must be powers of two
   localparam int MAP_BITS_DEF   = 4096;
   localparam int BLOCK_BITS_DEF = 1024;
   localparam int WORD_BITS_DEF  = 64;

   // Fixed field widths
   localparam int KIND_W      = 3;
   localparam int INDEX_W     = 12;
   localparam int LIMIT_W     = 13;
   localparam int STATUS_W    = 2;
   localparam int DBLOCK_W    = 2;
   localparam int VALID_RESET = 4096;

   // Request operations; code 7 is unused and ignored
   typedef enum logic [KIND_W-1:0] {
      KIND_SET        = 3'd0,
      KIND_CLEAR      = 3'd1,
      KIND_TEST_SET   = 3'd2,
      KIND_TEST_CLEAR = 3'd3,
      KIND_TEST       = 3'd4,
      KIND_FIND       = 3'd5,
      KIND_FIND_SET   = 3'd6
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_NONE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_HOLD
   } state_type;

   typedef struct packed {
      status_type          status;
      logic                old_bit;
      logic [INDEX_W-1:0]  found_index;
      logic                dirtied;
      logic [DBLOCK_W-1:0] dirty_block;
   } result_type;

endpackage

// File: rtl/core/balloc_map_mem.sv
// Bitmap word store: one write port and one read port, read data registered.
// Depends on nothing; sized by the top level.
module balloc_map_mem #(
   parameter int WORD_BITS = 64,
   parameter int ADDR_W    = 6,
   parameter int DEPTH     = 64
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, read data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/balloc_first_one.sv
// Lowest set bit finder over one bitmap word.
// Depends on nothing; width set by the top level.
module balloc_first_one #(
   parameter int WORD_BITS = 64,
   parameter int WIDX_W    = 6
) (
   input  logic [WORD_BITS-1:0] vec,
   output logic                 hit,
   output logic [WIDX_W-1:0]    pos
);

   // scan from the top so the lowest set bit wins
   always_comb begin
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = WIDX_W'(i);
         end
      end
   end

   assign hit = |vec;

endmodule

// File: rtl/core/bitmap_allocator_top.sv
// Bitmap allocator top level: sequencer, config register, dirty marks and result register.
// Depends on balloc_pkg, balloc_map_mem and balloc_first_one.

// The bitmap lives in one synchronous memory of MAP_BITS/WORD_BITS words (64 by default).
// After reset a clearing pass writes every word to zero, one word a cycle; req_stall stays high
// during it, while csr writes are taken. Set, clear and the test kinds read the word in the
// accept cycle and modify and write it back in the next. Out-of-range indices and the unused
// kind take the same path. A find walks one word per cycle through the memory read port. A
// new item is accepted while the previous result still waits in the output register; a second
// finished result then waits in a hold register until the first is taken. MAP_BITS, BLOCK_BITS
// and WORD_BITS must be powers of two. The usable limit is min(valid_bits, MAP_BITS).
module bitmap_allocator_top #(
   parameter int MAP_BITS   = balloc_pkg::MAP_BITS_DEF,
   parameter int BLOCK_BITS = balloc_pkg::BLOCK_BITS_DEF,
   parameter int WORD_BITS  = balloc_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [balloc_pkg::KIND_W-1:0]      req_kind,
   input  logic [balloc_pkg::INDEX_W-1:0]     req_bit_index,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [balloc_pkg::STATUS_W-1:0]    rsp_status,
   output logic                               rsp_old_bit,
   output logic [balloc_pkg::INDEX_W-1:0]     rsp_found_index,
   output logic                               rsp_dirtied,
   output logic [balloc_pkg::DBLOCK_W-1:0]    rsp_dirty_block,
   // configuration
   input  logic                               csr_we,
   input  logic [balloc_pkg::LIMIT_W-1:0]     csr_wdata
);

   localparam int NUM_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int NUM_BLOCKS = (MAP_BITS + BLOCK_BITS - 1) / BLOCK_BITS;
   localparam int ADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int WIDX_W     = $clog2(WORD_BITS);
   localparam int BLK_SH     = $clog2(BLOCK_BITS);
   localparam int LIM_W      = balloc_pkg::LIMIT_W;

   balloc_pkg::state_type  state_ff, state_in;
   balloc_pkg::kind_type   kind_ff, kind_in;
   logic [LIM_W-1:0]       pos_ff, pos_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [LIM_W-1:0]       valid_bits_ff, valid_bits_in;
   logic [NUM_BLOCKS-1:0]  dirty_ff, dirty_in;
   balloc_pkg::result_type res_ff, res_in;
   balloc_pkg::result_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   balloc_pkg::result_type res_comb;
   logic                   mem_we, mem_re;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0]   mem_wdata, mem_rdata;

   logic [LIM_W-1:0]       limit;
   logic [LIM_W-1:0]       base;
   logic [LIM_W:0]         next_base;
   logic [LIM_W-1:0]       rem;
   logic [WIDX_W-1:0]      off;
   logic [WORD_BITS-1:0]   start_mask, lim_mask, bit_mask, cand;
   logic                   ffo_hit;
   logic [WIDX_W-1:0]      ffo_pos;
   logic [WIDX_W-1:0]      wr_pos;
   logic [LIM_W-1:0]       found_pos, chg_pos;
   logic                   out_free, done, dirty_set, prior, changed;
   logic [BIDX_W-1:0]      blk_idx;

   // usable limit, saturated to the map size
   always_comb begin
      if (32'(valid_bits_ff) > MAP_BITS) begin
         limit = LIM_W'(MAP_BITS);
      end else begin
         limit = valid_bits_ff;
      end
   end

   // word-level search masks
   assign off        = pos_ff[WIDX_W-1:0];
   assign base       = pos_ff & ~LIM_W'(WORD_BITS - 1);
   assign next_base  = {1'b0, base} + (LIM_W + 1)'(WORD_BITS);
   assign rem        = limit - base;
   assign start_mask = {WORD_BITS{1'b1}} << off;
   assign lim_mask   = (32'(rem) >= WORD_BITS) ? {WORD_BITS{1'b1}}
                                              : ~({WORD_BITS{1'b1}} << rem[WIDX_W-1:0]);
   assign cand       = ~mem_rdata & start_mask & lim_mask;
   assign found_pos  = base | LIM_W'(ffo_pos);
   assign bit_mask   = WORD_BITS'(1) << wr_pos;
   assign prior      = mem_rdata[off];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign blk_idx    = BIDX_W'(chg_pos >> BLK_SH);

   balloc_first_one #(
      .WORD_BITS (WORD_BITS),
      .WIDX_W    (WIDX_W)
   ) u_first_one (
      .vec (cand),
      .hit (ffo_hit),
      .pos (ffo_pos)
   );

   balloc_map_mem #(
      .WORD_BITS (WORD_BITS),
      .ADDR_W    (ADDR_W),
      .DEPTH     (NUM_WORDS)
   ) u_map_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // sequencer: next state, memory control and result
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      clr_in        = clr_ff;
      valid_bits_in = csr_we ? csr_wdata : valid_bits_ff;
      dirty_in      = dirty_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = 1'b1;
      mem_we        = 1'b0;
      mem_waddr     = ADDR_W'(pos_ff >> WIDX_W);
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = ADDR_W'(req_bit_index >> WIDX_W);
      res_comb      = '0;
      res_comb.status = balloc_pkg::STATUS_OK;
      done          = 1'b0;
      dirty_set     = 1'b0;
      changed       = 1'b0;
      wr_pos        = off;
      chg_pos       = pos_ff;

      unique case (state_ff)
         balloc_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(NUM_WORDS - 1)) begin
               state_in = balloc_pkg::ST_IDLE;
            end
         end

         balloc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mem_re   = 1'b1;
               kind_in  = balloc_pkg::kind_type'(req_kind);
               pos_in   = LIM_W'(req_bit_index);
               state_in = balloc_pkg::ST_EVAL;
            end
         end

         balloc_pkg::ST_EVAL: begin
            if (pos_ff >= limit) begin
               // the unused kind is also finished here, with its status left at OK
               done = 1'b1;
               if (kind_ff <= balloc_pkg::KIND_FIND_SET) begin
                  res_comb.status = balloc_pkg::STATUS_RANGE;
               end
            end else begin
               unique case (kind_ff)
                  balloc_pkg::KIND_SET, balloc_pkg::KIND_TEST_SET: begin
                     done    = 1'b1;
                     changed = !prior;
                     res_comb.old_bit = (kind_ff == balloc_pkg::KIND_TEST_SET) && prior;
                  end
                  balloc_pkg::KIND_CLEAR, balloc_pkg::KIND_TEST_CLEAR: begin
                     done    = 1'b1;
                     changed = prior;
                     res_comb.old_bit = (kind_ff == balloc_pkg::KIND_TEST_CLEAR) && prior;
                  end
                  balloc_pkg::KIND_TEST: begin
                     done = 1'b1;
                     res_comb.old_bit = prior;
                  end
                  balloc_pkg::KIND_FIND, balloc_pkg::KIND_FIND_SET: begin
                     if (ffo_hit) begin
                        done    = 1'b1;
                        wr_pos  = ffo_pos;
                        chg_pos = found_pos;
                        changed = (kind_ff == balloc_pkg::KIND_FIND_SET);
                        res_comb.found_index = found_pos[balloc_pkg::INDEX_W-1:0];
                     end else if (next_base >= {1'b0, limit}) begin
                        done = 1'b1;
                        res_comb.status = balloc_pkg::STATUS_NONE;
                     end else begin
                        // walk on to the next word
                        pos_in    = next_base[LIM_W-1:0];
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(next_base >> WIDX_W);
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end

            // write back a changed bit and mark its block
            if (changed) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata ^ bit_mask;
               dirty_set = 1'b1;
               dirty_in[blk_idx]    = 1'b1;
               res_comb.dirtied     = 1'b1;
               res_comb.dirty_block = balloc_pkg::DBLOCK_W'(chg_pos >> BLK_SH);
            end

            if (done) begin
               if (out_free) begin
                  rsp_in       = res_comb;
                  rsp_valid_in = 1'b1;
                  state_in     = balloc_pkg::ST_IDLE;
               end else begin
                  res_in   = res_comb;
                  state_in = balloc_pkg::ST_HOLD;
               end
            end
         end

         balloc_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = balloc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = balloc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= balloc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         valid_bits_ff <= LIM_W'(balloc_pkg::VALID_RESET);
         dirty_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         valid_bits_ff <= valid_bits_in;
         dirty_ff      <= dirty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_old_bit     = rsp_ff.old_bit;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_dirtied     = rsp_ff.dirtied;
   assign rsp_dirty_block = rsp_ff.dirty_block;

   // no item is taken while the map is being cleared
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == balloc_pkg::ST_CLEAR) |-> req_stall)
      else $error("item accepted during clearing pass");

   // a bit change always leaves its block marked dirty
   a_dirty_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == balloc_pkg::ST_EVAL && dirty_set) |=> dirty_ff[$past(blk_idx)])
      else $error("changed block not marked dirty");

   // memory writes during evaluation only come with a successful change
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == balloc_pkg::ST_EVAL && mem_we) |->
         (res_comb.status == balloc_pkg::STATUS_OK && res_comb.dirtied))
      else $error("map written without a reported change");

   // failed requests report nothing else
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != balloc_pkg::STATUS_OK) |->
         (!rsp_ff.dirtied && rsp_ff.found_index == '0 && !rsp_ff.old_bit))
      else $error("failed item carries result data");

endmodule
